[sv/tbg_pkg.sv]
`default_nettype none

package tbg_pkg;

    localparam int CHROM_W      = 10;
    localparam int COORD_W      = 31;
    localparam int OUT_IDX_W    = 6;
    localparam int RESULT_LIMIT = 64;
    localparam int GRP_CNT_W    = 7;

    typedef struct packed {
        logic [CHROM_W-1:0] first_chrom;
        logic [CHROM_W-1:0] second_chrom;
        logic               reversed;
        logic [COORD_W-1:0] first_begin;
        logic [COORD_W-1:0] first_finish;
        logic [COORD_W-1:0] second_begin;
        logic [COORD_W-1:0] second_finish;
    } t_block;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] group_first;
        logic [OUT_IDX_W-1:0] group_final;
        logic                 inverted;
        logic [CHROM_W-1:0]   first_chrom;
        logic [COORD_W-1:0]   first_begin;
        logic [COORD_W-1:0]   first_finish;
        logic [CHROM_W-1:0]   second_chrom;
        logic [COORD_W-1:0]   second_begin;
        logic [COORD_W-1:0]   second_finish;
        logic                 last_group;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_EVAL,
        ST_JRD,
        ST_JCHK,
        ST_EMIT,
        ST_ADV,
        ST_END,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_j;
        logic cap_cur;
        logic open_grp;
        logic j_clr;
        logic j_inc;
        logic emit;
        logic tail;
        logic adv;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic cur_tl;
        logic cur_match;
        logic open;
        logic hit;
        logic j_skip;
        logic j_last;
        logic i_last;
        logic emit_ok;
        logic flush_ok;
    } t_sts;

endpackage

`default_nettype wire

[sv/tbg_ram.sv]
`default_nettype none

module tbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/tbg_ctrl.sv]
`default_nettype none

module tbg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_is_last,
    output logic               o_in_stall,
    output tbg_pkg::t_cmd      o_cmd,
    input  wire tbg_pkg::t_sts i_sts
);

    import tbg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_is_last) begin
                        n_state = ST_RD_CUR;
                    end
                end
            end
            ST_RD_CUR: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.cap_cur = 1'b1;
                if (!i_sts.cur_tl) begin
                    n_state = i_sts.open ? ST_EMIT : ST_ADV;
                end else if (!i_sts.open) begin
                    o_cmd.open_grp = 1'b1;
                    n_state        = ST_ADV;
                end else if (!i_sts.cur_match) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.j_clr = 1'b1;
                    n_state     = ST_JRD;
                end
            end
            ST_JRD: begin
                o_cmd.rd_j = 1'b1;
                n_state    = ST_JCHK;
            end
            ST_JCHK: begin
                // another block starts between the two: break the group
                if (i_sts.hit && !i_sts.j_skip) begin
                    n_state = ST_EMIT;
                end else if (i_sts.j_last) begin
                    n_state = ST_ADV;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = ST_JRD;
                end
            end
            ST_EMIT: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_ADV;
                end
            end
            ST_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = i_sts.i_last ? ST_END : ST_RD_CUR;
            end
            ST_END: begin
                if (!i_sts.open) begin
                    n_state = ST_FLUSH;
                end else if (i_sts.emit_ok) begin
                    o_cmd.tail = 1'b1;
                    n_state    = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_sts.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tbg_dp.sv]
`default_nettype none

module tbg_dp #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tbg_pkg::t_cmd   i_cmd,
    output tbg_pkg::t_sts        o_sts,
    input  wire tbg_pkg::t_block i_blk,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output tbg_pkg::t_result     o_res
);

    import tbg_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int EXT_W = IDX_W + OUT_IDX_W;

    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_i;
    logic [IDX_W-1:0]     r_j;
    logic                 r_open;
    logic [IDX_W-1:0]     r_start;
    t_block               r_start_blk;
    t_block               r_cur;
    t_block               r_prev;
    logic [GRP_CNT_W-1:0] r_grp_cnt;
    logic                 r_pend_v;
    t_result              r_pend;
    logic                 r_out_v;
    t_result              r_out;

    t_block           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] i_m1;
    logic [IDX_W-1:0] b_idx;
    logic [EXT_W-1:0] a_ext;
    logic [EXT_W-1:0] b_ext;
    logic             cur_reg_tl;
    logic             out_free;
    logic             push;
    logic             load_out;
    t_result          new_res;
    t_result          out_next;

    assign wr_en   = i_cmd.load && (r_count < CNT_W'(MAX_BLOCKS));
    assign rd_addr = i_cmd.rd_j ? r_j : r_i;

    tbg_ram #(
        .WIDTH ($bits(t_block)),
        .DEPTH (MAX_BLOCKS),
        .ADDR_W(IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[IDX_W-1:0]),
        .i_wr_data(i_blk),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign i_m1       = r_i - 1'b1;
    assign cur_reg_tl = r_cur.first_chrom != r_cur.second_chrom;
    assign out_free   = !r_out_v || !i_out_stall;

    always_comb begin
        o_sts           = '0;
        o_sts.cur_tl    = rd_data.first_chrom != rd_data.second_chrom;
        o_sts.cur_match = (rd_data.second_chrom == r_prev.second_chrom)
                          && (rd_data.reversed == r_prev.reversed);
        o_sts.open      = r_open;
        o_sts.hit       = ((rd_data.second_begin > r_cur.second_begin)
                           && (rd_data.second_begin < r_prev.second_begin))
                          || ((rd_data.second_begin < r_cur.second_begin)
                           && (rd_data.second_begin > r_prev.second_begin));
        o_sts.j_skip    = (r_j == r_i) || (r_j == i_m1);
        o_sts.j_last    = (CNT_W'(r_j) + CNT_W'(1)) == r_count;
        o_sts.i_last    = (CNT_W'(r_i) + CNT_W'(1)) == r_count;
        o_sts.emit_ok   = (r_grp_cnt == GRP_CNT_W'(RESULT_LIMIT)) || !r_pend_v || out_free;
        o_sts.flush_ok  = !r_pend_v || out_free;
    end

    // group ends at the block before the current one, or at the tail of the list
    assign b_idx = i_cmd.tail ? r_i : i_m1;
    assign a_ext = EXT_W'(r_start);
    assign b_ext = EXT_W'(b_idx);

    always_comb begin
        new_res.group_first  = a_ext[OUT_IDX_W-1:0];
        new_res.group_final  = b_ext[OUT_IDX_W-1:0];
        new_res.inverted     = r_start_blk.reversed;
        new_res.first_chrom  = r_start_blk.first_chrom;
        new_res.first_begin  = r_start_blk.first_begin;
        new_res.first_finish = r_prev.first_finish;
        new_res.second_chrom = r_start_blk.second_chrom;
        if (r_start_blk.reversed) begin
            new_res.second_begin  = r_prev.second_begin;
            new_res.second_finish = r_start_blk.second_finish;
        end else begin
            new_res.second_begin  = r_start_blk.second_begin;
            new_res.second_finish = r_prev.second_finish;
        end
        new_res.last_group = 1'b0;
    end

    assign push     = (i_cmd.emit || i_cmd.tail) && (r_grp_cnt != GRP_CNT_W'(RESULT_LIMIT));
    assign load_out = r_pend_v && (push || i_cmd.flush);

    always_comb begin
        out_next            = r_pend;
        out_next.last_group = i_cmd.flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_open    <= 1'b0;
            r_grp_cnt <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + 1'b1;
            end

            if (i_cmd.load) begin
                r_i <= '0;
            end else if (i_cmd.adv && !o_sts.i_last) begin
                r_i <= r_i + 1'b1;
            end

            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end

            if (i_cmd.load) begin
                r_open <= 1'b0;
            end else if (i_cmd.open_grp) begin
                r_open <= 1'b1;
            end else if (i_cmd.emit) begin
                r_open <= cur_reg_tl;
            end

            if (i_cmd.load) begin
                r_grp_cnt <= '0;
            end else if (push) begin
                r_grp_cnt <= r_grp_cnt + 1'b1;
            end

            if (push) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end

            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_cur) begin
            r_cur <= rd_data;
        end
        if (i_cmd.adv) begin
            r_prev <= r_cur;
        end
        if (i_cmd.open_grp) begin
            r_start     <= r_i;
            r_start_blk <= rd_data;
        end else if (i_cmd.emit) begin
            r_start     <= r_i;
            r_start_blk <= r_cur;
        end
        if (push) begin
            r_pend <= new_res;
        end
        if (load_out) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_res       = r_out;

    a_out_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_v || !i_out_stall))
        else $error("result register overwritten while stalled");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (!r_pend_v && (r_count == '0)))
        else $error("pending result or block count left after flush");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond list depth");

    a_grp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_cnt <= GRP_CNT_W'(RESULT_LIMIT))
        else $error("group count beyond result limit");

endmodule

`default_nettype wire

[sv/translocation_block_grouper.sv]
`default_nettype none

// Translocation block grouper. Alignment blocks load one per cycle into the
// block store (up to MAX_BLOCKS; further blocks of a list are dropped, but
// their last flag still counts). The request marked last starts a scan, during
// which o_in_stall stays high. The scan visits every stored block in turn, takes
// an emit step for each group that closes before a later block, and then
// finishes the list. For each adjacent pair of translocation blocks on the same
// second-genome chromosome and direction, a between-start check walks the whole
// store through its single read port, and stops at the first block that splits
// the pair.
// One result goes out per group, at most 64 per list, the final one with
// o_last_group set; a list without translocation gives no result. Results wait
// in a one-deep pending stage plus the output register, so a stalled output
// pauses the scan. The block store needs no clearing after reset.
module translocation_block_grouper #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [9:0]  i_first_chrom,
    input  wire logic [9:0]  i_second_chrom,
    input  wire logic        i_reversed,
    input  wire logic [30:0] i_first_begin,
    input  wire logic [30:0] i_first_finish,
    input  wire logic [30:0] i_second_begin,
    input  wire logic [30:0] i_second_finish,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_group_first,
    output logic [5:0]       o_group_final,
    output logic             o_inverted,
    output logic [9:0]       o_out_first_chrom,
    output logic [30:0]      o_out_first_begin,
    output logic [30:0]      o_out_first_finish,
    output logic [9:0]       o_out_second_chrom,
    output logic [30:0]      o_out_second_begin,
    output logic [30:0]      o_out_second_finish,
    output logic             o_last_group
);

    import tbg_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_block  blk;
    t_result res;

    always_comb begin
        blk.first_chrom   = i_first_chrom;
        blk.second_chrom  = i_second_chrom;
        blk.reversed      = i_reversed;
        blk.first_begin   = i_first_begin;
        blk.first_finish  = i_first_finish;
        blk.second_begin  = i_second_begin;
        blk.second_finish = i_second_finish;
    end

    tbg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_is_last (i_is_last),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    tbg_dp #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_blk      (blk),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_res      (res)
    );

    assign o_group_first       = res.group_first;
    assign o_group_final       = res.group_final;
    assign o_inverted          = res.inverted;
    assign o_out_first_chrom   = res.first_chrom;
    assign o_out_first_begin   = res.first_begin;
    assign o_out_first_finish  = res.first_finish;
    assign o_out_second_chrom  = res.second_chrom;
    assign o_out_second_begin  = res.second_begin;
    assign o_out_second_finish = res.second_finish;
    assign o_last_group        = res.last_group;

endmodule

`default_nettype wire
